>>> sv/heater_actuator_test_sequencer_unit_assert.svh
// assertion macros for the heater actuator test sequencer
`ifndef HEATER_ACTUATOR_TEST_SEQUENCER_UNIT_ASSERT_SVH
`define HEATER_ACTUATOR_TEST_SEQUENCER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HATS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// antecedent implies consequent in the next cycle
`define HATS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

>>> sv/hats_pkg.sv
// constants shared by the heater actuator test sequencer
`timescale 1ns / 1ps
package hats_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned PHASE_W = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [TOTAL_W-1:0] TOTAL_CAP = 17'd120000;
  localparam logic [PHASE_W-1:0] PHASE_CAP = 9'd400;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEST_SELECT_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_DURATION    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DURATION      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_DURATION       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_HOLD_DURATION = 3'd4;

endpackage

>>> sv/heater_actuator_test_sequencer_unit.sv
// heater actuator test sequencer, top level
`timescale 1ns / 1ps
// One input transfer is one tick and yields one result transfer. The tick is
// decoded and the sequence state updated in the cycle it is accepted; the
// updated state registers are the result, so the result is offered on the
// next cycle and a new tick can be taken every cycle as long as the result
// side takes its transfers. While a result waits, no tick is taken. Durations
// are clamped to their caps (400 for phases, once bits above the phase width
// are dropped; 120000 for total and end hold) as the registers are written.
`include "heater_actuator_test_sequencer_unit_assert.svh"
module heater_actuator_test_sequencer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // service_enable [0], requested_code [8:1], zero [15:9]
  input  logic [hats_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // heater_command [0], relay_command [1], test_done [2], phase [4:3], zero [7:5]
  output logic [hats_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [hats_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hats_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hats_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OFF  = 2'd1,
    PH_ON   = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  // configuration, held already clamped
  logic [CODE_W-1:0]  test_select_code;
  logic [TOTAL_W-1:0] total_duration;
  logic [PHASE_W-1:0] off_duration;
  logic [PHASE_W-1:0] on_duration;
  logic [TOTAL_W-1:0] end_hold_duration;

  phase_t             phase_reg, phase_reg_next;
  logic [TOTAL_W-1:0] remaining_total, remaining_total_next;
  logic [PHASE_W-1:0] remaining_phase, remaining_phase_next;
  logic [TOTAL_W-1:0] hold_count, hold_count_next;
  logic               heater_reg, heater_reg_next;
  logic               relay_reg, relay_reg_next;
  logic               done_reg, done_reg_next;
  logic               out_valid;

  logic               accept;
  logic               enabled;
  logic [TOTAL_W-1:0] cfg_total_clamped;
  logic [PHASE_W-1:0] cfg_phase_clamped;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign enabled  = s_tdata[0] && (s_tdata[CODE_W:1] == test_select_code);

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, phase_reg, done_reg, relay_reg, heater_reg};

  assign cfg_total_clamped = (cfg_data > TOTAL_CAP) ? TOTAL_CAP : cfg_data;
  // bits above the phase register width are ignored before the clamp
  assign cfg_phase_clamped = (cfg_data[PHASE_W-1:0] > PHASE_CAP) ?
                             PHASE_CAP : cfg_data[PHASE_W-1:0];

  always_comb begin
    phase_reg_next       = phase_reg;
    remaining_total_next = remaining_total;
    remaining_phase_next = remaining_phase;
    hold_count_next      = hold_count;
    heater_reg_next      = heater_reg;
    relay_reg_next       = relay_reg;
    done_reg_next        = done_reg;
    unique case (phase_reg)
      PH_IDLE: begin
        if (enabled) begin
          phase_reg_next       = PH_OFF;
          remaining_total_next = total_duration;
          remaining_phase_next = off_duration;
          heater_reg_next      = 1'b0;
          relay_reg_next       = 1'b0;
        end
      end
      PH_OFF, PH_ON: begin
        if (!enabled) begin
          phase_reg_next  = PH_IDLE;
          heater_reg_next = 1'b0;
          relay_reg_next  = 1'b0;
          done_reg_next   = 1'b0;
        end else if (remaining_total <= TOTAL_W'(1)) begin
          phase_reg_next  = PH_END;
          heater_reg_next = 1'b0;
          relay_reg_next  = 1'b0;
          done_reg_next   = 1'b1;
          hold_count_next = end_hold_duration;
        end else begin
          if (remaining_phase <= PHASE_W'(1)) begin
            if (phase_reg == PH_OFF) begin
              phase_reg_next       = PH_ON;
              heater_reg_next      = 1'b1;
              relay_reg_next       = 1'b1;
              remaining_phase_next = on_duration;
            end else begin
              phase_reg_next       = PH_OFF;
              heater_reg_next      = 1'b0;
              relay_reg_next       = 1'b0;
              remaining_phase_next = off_duration;
            end
          end else begin
            remaining_phase_next = remaining_phase - PHASE_W'(1);
          end
          remaining_total_next = remaining_total - TOTAL_W'(1);
        end
      end
      PH_END: begin
        // restart only once the hold has run out and the test is still requested
        if (enabled && hold_count == '0) begin
          phase_reg_next  = PH_IDLE;
          heater_reg_next = 1'b0;
          relay_reg_next  = 1'b0;
          done_reg_next   = 1'b0;
        end else if (hold_count != '0) begin
          hold_count_next = hold_count - TOTAL_W'(1);
        end
      end
      default: begin
        phase_reg_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      test_select_code  <= '0;
      total_duration    <= '0;
      off_duration      <= '0;
      on_duration       <= '0;
      end_hold_duration <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEST_SELECT_CODE:  test_select_code  <= cfg_data[CODE_W-1:0];
        REG_TOTAL_DURATION:    total_duration    <= cfg_total_clamped;
        REG_OFF_DURATION:      off_duration      <= cfg_phase_clamped;
        REG_ON_DURATION:       on_duration       <= cfg_phase_clamped;
        REG_END_HOLD_DURATION: end_hold_duration <= cfg_total_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= PH_IDLE;
      remaining_total <= '0;
      remaining_phase <= '0;
      hold_count      <= '0;
      heater_reg      <= 1'b0;
      relay_reg       <= 1'b0;
      done_reg        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase_reg       <= phase_reg_next;
        remaining_total <= remaining_total_next;
        remaining_phase <= remaining_phase_next;
        hold_count      <= hold_count_next;
        heater_reg      <= heater_reg_next;
        relay_reg       <= relay_reg_next;
        done_reg        <= done_reg_next;
        out_valid       <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // heater and relay only driven in the on phase, done only in the end state
  `HATS_ASSERT_SAME(a_drive_only_on, heater_reg || relay_reg, phase_reg == PH_ON && heater_reg && relay_reg)
  `HATS_ASSERT_SAME(a_done_in_end, 1'b1, done_reg == (phase_reg == PH_END))
  `HATS_ASSERT_SAME(a_counters_capped, 1'b1, remaining_phase <= PHASE_CAP && remaining_total <= TOTAL_CAP && hold_count <= TOTAL_CAP)
  `HATS_ASSERT_NEXT(a_hold_counts_down, accept && phase_reg == PH_END && hold_count != '0, hold_count == $past(hold_count) - TOTAL_W'(1))

endmodule
